### src/fpst_pkg.sv
// Shared constants, command codes and state type for the prefix sum table.
`timescale 1ns / 1ps
package fpst_pkg;

    localparam int MAX_ENTRIES = 1024;
    localparam int ADDR_W      = $clog2(MAX_ENTRIES);
    localparam int DATA_W      = 32;
    localparam int IDX_W       = 10;
    localparam int CMD_W       = 3;
    localparam int CFG_W       = 11;
    // Node numbers run 1..MAX_ENTRIES; wide enough for the size register too.
    localparam int PW          = ((ADDR_W + 1) > CFG_W) ? (ADDR_W + 1) : CFG_W;

    localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(1024);

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_POINT_ADD  = 3'd0,
        CMD_RANGE_ADD  = 3'd1,
        CMD_PREFIX_SUM = 3'd2,
        CMD_RANGE_SUM  = 3'd3,
        CMD_CLEAR      = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLR,
        S_RD,
        S_WALK,
        S_DONE
    } t_state;

endpackage

### src/fpst_ram.sv
// Simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module fpst_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

### src/fenwick_prefix_sum_table_unit.sv
// Top level: binary indexed tree of 32-bit counters over a single node RAM.
// A point add or prefix sum runs one tree walk; range add and range sum run up to
// two walks. No new word is taken until the last result is in the output register.
// The result word appears in the same cycle that the next word can be taken. Each walk
// step reads one node and, for adds, writes it back, so the walk length sets the rate.
// Clear sweeps the node RAM one node per cycle.
// Reset (synchronous, active low) starts the same zeroing sweep; no word is
// accepted until it ends. Config writes are taken at any time.
`timescale 1ns / 1ps
module fenwick_prefix_sum_table_unit
    import fpst_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // config: size_in_use
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_W-1:0]       i_cfg_wr_data,
    // input words
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [2:0] command, [12:3] left_index, [22:13] right_index, [54:23] amount, [55] zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // result words
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [31:0] total
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // [0] bad_index
    output logic [0:0]             m_axis_tuser
);

    // ------------------------------------------------------------------
    // Input word fields
    // ------------------------------------------------------------------
    logic [CMD_W-1:0]  in_cmd;
    logic [IDX_W-1:0]  in_left;
    logic [IDX_W-1:0]  in_right;
    logic [DATA_W-1:0] in_amount;

    assign in_cmd    = s_axis_tdata[2:0];
    assign in_left   = s_axis_tdata[12:3];
    assign in_right  = s_axis_tdata[22:13];
    assign in_amount = s_axis_tdata[54:23];

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_state             r_state, n_state;
    logic [CFG_W-1:0]   r_size;
    logic               r_init;        // sweep is the post-reset one: no result
    logic [ADDR_W-1:0]  r_clr_cnt;
    logic [PW-1:0]      r_p;           // current node number (1-based)
    logic [PW-1:0]      r_p2;          // start node of the second walk
    logic               r_second;      // a second walk is pending
    logic               r_is_add;      // walk updates nodes instead of summing
    logic               r_sub;         // summing walk subtracts
    logic [DATA_W-1:0]  r_val;
    logic [DATA_W-1:0]  r_acc;
    logic               r_bad;
    logic               r_out_valid;
    logic [DATA_W-1:0]  r_out_total;
    logic               r_out_bad;

    // ------------------------------------------------------------------
    // Node RAM
    // ------------------------------------------------------------------
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    fpst_ram #(
        .DEPTH (MAX_ENTRIES),
        .WIDTH (DATA_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Effective size and index checks
    // ------------------------------------------------------------------
    logic [PW-1:0] size_ext;
    logic [PW-1:0] n_eff;
    logic [PW-1:0] left_ext;
    logic [PW-1:0] right_ext;
    logic          left_bad;
    logic          right_bad;
    logic          accept;
    logic          in_bad;
    logic          in_walk;

    assign size_ext  = PW'(r_size);
    assign n_eff     = (size_ext > PW'(MAX_ENTRIES)) ? PW'(MAX_ENTRIES) : size_ext;
    assign left_ext  = PW'(in_left);
    assign right_ext = PW'(in_right);
    assign left_bad  = (left_ext >= n_eff);
    assign right_bad = (right_ext >= n_eff);
    assign accept    = s_axis_tvalid && s_axis_tready;

    always_comb begin
        in_bad  = 1'b0;
        in_walk = 1'b0;
        unique case (t_cmd'(in_cmd))
            CMD_POINT_ADD: begin
                in_bad  = left_bad;
                in_walk = !left_bad;
            end
            CMD_RANGE_ADD, CMD_RANGE_SUM: begin
                in_bad  = left_bad || right_bad;
                in_walk = !(left_bad || right_bad);
            end
            CMD_PREFIX_SUM: begin
                in_bad  = right_bad;
                in_walk = !right_bad;
            end
            default: begin
                in_bad  = 1'b0;
                in_walk = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Walk step arithmetic
    // Add walks climb: p += lowbit(p). Sum walks descend: p &= p - 1.
    // ------------------------------------------------------------------
    logic [PW-1:0] lowbit;
    logic [PW:0]   next_add;
    logic [PW-1:0] next_sum;
    logic          walk_cont;
    logic [PW-1:0] next_p;
    logic          out_free;

    assign lowbit    = r_p & (~r_p + PW'(1));
    assign next_add  = {1'b0, r_p} + {1'b0, lowbit};
    assign next_sum  = r_p & (r_p - PW'(1));
    assign walk_cont = r_is_add ? (next_add <= {1'b0, n_eff}) : (next_sum != '0);
    assign next_p    = r_is_add ? next_add[PW-1:0] : next_sum;
    assign out_free  = !r_out_valid || m_axis_tready;

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (t_cmd'(in_cmd) == CMD_CLEAR) begin
                        n_state = S_CLR;
                    end else if (in_walk) begin
                        n_state = S_RD;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_CLR: begin
                if (r_clr_cnt == ADDR_W'(MAX_ENTRIES - 1)) begin
                    n_state = r_init ? S_IDLE : S_DONE;
                end
            end
            S_RD: begin
                n_state = S_WALK;
            end
            S_WALK: begin
                if (walk_cont) begin
                    n_state = S_WALK;
                end else if (r_second) begin
                    // pass through S_RD so the last write lands before the next read
                    n_state = S_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Outputs of the sequencer: RAM controls and input ready
    // ------------------------------------------------------------------
    always_comb begin
        s_axis_tready = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = ADDR_W'(r_p - PW'(1));
        ram_wdata     = ram_rdata + r_val;
        ram_re        = 1'b0;
        ram_raddr     = ADDR_W'(r_p - PW'(1));
        unique case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
            end
            S_CLR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_cnt;
                ram_wdata = '0;
            end
            S_RD: begin
                ram_re = 1'b1;
            end
            S_WALK: begin
                // write back the current node on adds, fetch the next one in the same cycle
                ram_we    = r_is_add;
                ram_re    = walk_cont;
                ram_raddr = ADDR_W'(next_p - PW'(1));
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_init      <= 1'b1;
            r_clr_cnt   <= '0;
            r_size      <= SIZE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_size <= i_cfg_wr_data;
            end
            if (r_state == S_CLR) begin
                r_clr_cnt <= r_clr_cnt + ADDR_W'(1);
                if (r_clr_cnt == ADDR_W'(MAX_ENTRIES - 1)) begin
                    r_init <= 1'b0;
                end
            end else if (accept) begin
                r_clr_cnt <= '0;
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_acc <= '0;
            r_val <= in_amount;
            r_sub <= 1'b0;
            r_bad <= in_bad;
            unique case (t_cmd'(in_cmd))
                CMD_POINT_ADD: begin
                    r_is_add <= 1'b1;
                    r_p      <= left_ext + PW'(1);
                    r_p2     <= left_ext;
                    r_second <= 1'b0;
                end
                CMD_RANGE_ADD: begin
                    // end correction just past the right end, unless the right end is the last node
                    r_is_add <= 1'b1;
                    r_p      <= left_ext + PW'(1);
                    r_p2     <= right_ext + PW'(2);
                    r_second <= ((right_ext + PW'(1)) < n_eff);
                end
                CMD_RANGE_SUM: begin
                    r_is_add <= 1'b0;
                    r_p      <= right_ext + PW'(1);
                    r_p2     <= left_ext;
                    r_second <= (in_left != '0);
                end
                default: begin
                    r_is_add <= 1'b0;
                    r_p      <= right_ext + PW'(1);
                    r_p2     <= left_ext;
                    r_second <= 1'b0;
                end
            endcase
        end else if (r_state == S_WALK) begin
            if (!r_is_add) begin
                r_acc <= r_sub ? (r_acc - ram_rdata) : (r_acc + ram_rdata);
            end
            if (walk_cont) begin
                r_p <= next_p;
            end else if (r_second) begin
                r_p      <= r_p2;
                r_second <= 1'b0;
                r_val    <= '0 - r_val;
                r_sub    <= 1'b1;
            end
        end
        if (r_state == S_DONE && out_free) begin
            r_out_total <= r_acc;
            r_out_bad   <= r_bad;
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_total;
    assign m_axis_tuser[0] = r_out_bad;

endmodule

### src/fpst_checker.sv
// Port-level checks on the prefix sum table, bound to the top level.
`timescale 1ns / 1ps
module fpst_checker
    import fpst_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [0:0]             m_axis_tuser
);

    // held result stays put until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    // an ignored item reports a zero total
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("bad index with nonzero total");

    // one item at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second word accepted while busy");

    // zeroing sweep blocks input right after reset
    a_reset_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !s_axis_tready && !m_axis_tvalid)
        else $error("ready or valid right after reset");

endmodule

bind fenwick_prefix_sum_table_unit fpst_checker u_fpst_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
